// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Full form: explicit clock and active-low reset.
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Short form on the block clock and reset.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/gcd11_pkg.sv
// Shared constants, types and the divide-by-11 digit function.
package gcd11_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int INT_WIDTH     = (OPERAND_WIDTH + 10 > 64) ? 64 : OPERAND_WIDTH + 10;
  localparam int REDUCE_FACTOR = 11;
  localparam int REM_WIDTH     = $clog2(REDUCE_FACTOR);
  localparam int DIGIT_BITS    = 7;
  localparam int NUM_DIGITS    = (INT_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PAD_WIDTH     = NUM_DIGITS * DIGIT_BITS;
  localparam int STEP_LIMIT    = 65536;
  localparam int STEP_WIDTH    = $clog2(STEP_LIMIT + 1);
  localparam int IN_DATA_W     = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W    = ((OPERAND_WIDTH + 7) / 8) * 8;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic update;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic done;
  } dp_status_t;

  typedef struct packed {
    logic [REM_WIDTH-1:0]  rem;
    logic [DIGIT_BITS-1:0] quo;
  } digit_res_t;

  // One digit of long division by 11: remainder in, quotient bits and remainder out.
  function automatic digit_res_t div_digit(input logic [REM_WIDTH-1:0]  rem_in,
                                           input logic [DIGIT_BITS-1:0] digit);
    digit_res_t         res;
    logic [REM_WIDTH:0] part;
    res.rem = rem_in;
    res.quo = '0;
    for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
      part = {res.rem, digit[i]};
      if (part >= (REM_WIDTH + 1)'(REDUCE_FACTOR)) begin
        part       = part - (REM_WIDTH + 1)'(REDUCE_FACTOR);
        res.quo[i] = 1'b1;
      end
      res.rem = part[REM_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/gcd11_ctrl.sv
// Sequencer: handshakes, reduction step sequencing and output valid.
module gcd11_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  gcd11_pkg::dp_status_t status_i,
  output gcd11_pkg::dp_cmd_t    cmd_o
);
  import gcd11_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TEST   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam int DCNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [2:0]        state_q, state_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    dcnt_d      = dcnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.zero || status_i.done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          dcnt_d          = '0;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(NUM_DIGITS - 1)) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_TEST;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/gcd11_datapath.sv
// Operand registers, digit-serial divide-by-11 lanes, scale and result register.
module gcd11_datapath (
  input  logic                                clk_i,
  input  gcd11_pkg::dp_cmd_t                  cmd_i,
  input  logic [gcd11_pkg::OPERAND_WIDTH-1:0] first_value_i,
  input  logic [gcd11_pkg::OPERAND_WIDTH-1:0] second_value_i,
  output gcd11_pkg::dp_status_t               status_o,
  output logic [gcd11_pkg::OPERAND_WIDTH-1:0] gcd_value_o
);
  import gcd11_pkg::*;

  logic [INT_WIDTH-1:0]     x_q, x_d, y_q, y_d;
  logic [OPERAND_WIDTH-1:0] scale_q, scale_d;
  logic [STEP_WIDTH-1:0]    steps_q, steps_d;
  logic                     zero_q, zero_d;
  logic [PAD_WIDTH-1:0]     xd_q, xd_d, yd_q, yd_d;
  logic [REM_WIDTH-1:0]     xr_q, xr_d, yr_q, yr_d;
  logic [OPERAND_WIDTH-1:0] result_q, result_d;

  digit_res_t               xdig, ydig;
  logic [INT_WIDTH-1:0]     qx, qy, diff, mn, x_dbl, y_dbl, fin, or_v;
  logic                     xm, ym;
  logic [OPERAND_WIDTH-1:0] scale11, prod;

  assign xdig  = div_digit(xr_q, xd_q[PAD_WIDTH-1 -: DIGIT_BITS]);
  assign ydig  = div_digit(yr_q, yd_q[PAD_WIDTH-1 -: DIGIT_BITS]);
  assign qx    = xd_q[INT_WIDTH-1:0];
  assign qy    = yd_q[INT_WIDTH-1:0];
  assign xm    = (xr_q == '0);
  assign ym    = (yr_q == '0);
  assign diff  = (x_q > y_q) ? (x_q - y_q) : (y_q - x_q);
  assign mn    = (x_q < y_q) ? x_q : y_q;
  assign x_dbl = {x_q[INT_WIDTH-2:0], 1'b0};
  assign y_dbl = {y_q[INT_WIDTH-2:0], 1'b0};
  assign scale11 = (scale_q << 3) + (scale_q << 1) + scale_q;
  assign fin   = (x_q == y_q) ? x_q : mn;
  assign or_v  = x_q | y_q;
  assign prod  = scale_q * fin[OPERAND_WIDTH-1:0];

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    scale_d  = scale_q;
    steps_d  = steps_q;
    zero_d   = zero_q;
    xd_d     = xd_q;
    yd_d     = yd_q;
    xr_d     = xr_q;
    yr_d     = yr_q;
    result_d = result_q;
    if (cmd_i.load) begin
      x_d     = INT_WIDTH'(first_value_i);
      y_d     = INT_WIDTH'(second_value_i);
      scale_d = OPERAND_WIDTH'(1);
      steps_d = '0;
      zero_d  = (first_value_i == '0) || (second_value_i == '0);
    end
    if (cmd_i.div_start) begin
      xd_d = PAD_WIDTH'(x_q);
      yd_d = PAD_WIDTH'(y_q);
      xr_d = '0;
      yr_d = '0;
    end
    if (cmd_i.div_step) begin
      // dividend shifts out at the top, quotient digits shift in at the bottom
      xd_d = {xd_q[PAD_WIDTH-DIGIT_BITS-1:0], xdig.quo};
      yd_d = {yd_q[PAD_WIDTH-DIGIT_BITS-1:0], ydig.quo};
      xr_d = xdig.rem;
      yr_d = ydig.rem;
    end
    if (cmd_i.update) begin
      steps_d = steps_q + 1'b1;
      if (xm && ym) begin
        x_d     = qx;
        y_d     = qy;
        scale_d = scale11;
      end else if (xm) begin
        y_d = x_q[0] ? y_dbl : diff;
        x_d = qx;
      end else if (ym) begin
        x_d = y_q[0] ? x_dbl : diff;
        y_d = qy;
      end else begin
        x_d = diff;
        y_d = mn;
      end
    end
    if (cmd_i.capture) begin
      result_d = zero_q ? or_v[OPERAND_WIDTH-1:0] : prod;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    scale_q  <= scale_d;
    steps_q  <= steps_d;
    zero_q   <= zero_d;
    xd_q     <= xd_d;
    yd_q     <= yd_d;
    xr_q     <= xr_d;
    yr_q     <= yr_d;
    result_q <= result_d;
  end

  assign status_o.zero = zero_q;
  assign status_o.done = (x_q == y_q) || (steps_q == STEP_WIDTH'(STEP_LIMIT));
  assign gcd_value_o   = result_q;

endmodule

// File: hdl/gcd_eleven_reduction.sv
// Top level: GCD by factor-11 reduction, stream in and stream out.
//
//   channel   dir  tdata fields (low bit up)                 notes
//   s_axis    in   first_value[31:0], second_value[63:32]    one operand pair per word
//   m_axis    out  gcd_value[31:0]                           one result per input word
//
// Each reduction step is a test, the digit-serial divide by 11 of both operands
// (7 bits a cycle), and the update; a zero or equal operand pair skips the steps.
// Input is taken only while the sequencer is idle; the result sits in an output
// register, so the next pair is accepted while a result waits on m_axis_tready_i.
// Reset clears the sequencer and the output valid; data registers are not reset.
module gcd_eleven_reduction (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [gcd11_pkg::IN_DATA_W-1:0] s_axis_tdata_i,   // first_value, second_value
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [gcd11_pkg::OUT_DATA_W-1:0] m_axis_tdata_o   // gcd_value
);
  import gcd11_pkg::*;

  dp_cmd_t                  cmd;
  dp_status_t               status;
  logic [OPERAND_WIDTH-1:0] gcd_value;

  gcd11_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gcd11_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .first_value_i  (s_axis_tdata_i[OPERAND_WIDTH-1:0]),
    .second_value_i (s_axis_tdata_i[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
    .status_o       (status),
    .gcd_value_o    (gcd_value)
  );

  assign m_axis_tdata_o = OUT_DATA_W'(gcd_value);

endmodule

// File: hdl/gcd11_checker.sv
// Port-level checker for the GCD block, bound to the top level.
`include "assert_macros.svh"

module gcd11_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [gcd11_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [gcd11_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // protocol: a stalled result stays valid and steady
  `ASSERT_STD(a_out_valid_hold,
              m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o,
              "result dropped while stalled")
  `ASSERT_STD(a_out_data_hold,
              m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o),
              "result changed while stalled")

  // an accepted pair keeps the block busy for at least the next cycle
  `ASSERT_STD(a_busy_after_accept,
              s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o,
              "input ready right after accept")

  // a new result only appears at the end of a run, never from the idle state
  `ASSERT_STD(a_result_from_run,
              $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o),
              "result raised while idle")

endmodule

bind gcd_eleven_reduction gcd11_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: test/gcd_eleven_reduction_tb.sv
// Self-checking stream testbench for the factor-11 GCD reduction block.
module gcd_eleven_reduction_tb;

  localparam int OW = gcd11_pkg::OPERAND_WIDTH;
  localparam int IW = gcd11_pkg::INT_WIDTH;
  localparam logic [IW-1:0] FACTOR = IW'(gcd11_pkg::REDUCE_FACTOR);
  localparam logic [OW-1:0] MAX_OPERAND = '1;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [gcd11_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;   // first_value, second_value
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i;
  logic [gcd11_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;   // gcd_value

  logic [OW-1:0] gcd_expected[$];
  int            error_count;
  bit            idling_on;
  int            stall_left;
  longint        cycle_count;
  longint        cycle_budget;

  gcd_eleven_reduction uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [IW-1:0] lesser_of(input logic [IW-1:0] x, input logic [IW-1:0] y);
    return (x < y) ? x : y;
  endfunction

  // Reduction on the internal width; steps counts loop iterations for the timeout budget.
  function automatic logic [OW-1:0] compute_gcd11(input logic [OW-1:0] a,
                                                  input logic [OW-1:0] b,
                                                  output int steps);
    logic [IW-1:0] x, y, scale, quo, diff, lesser, prod;
    bit            xm, ym;
    x     = IW'(a);
    y     = IW'(b);
    scale = IW'(1);
    steps = 0;
    if (x == '0) return b;
    if (y == '0) return a;
    while (x != y && steps < gcd11_pkg::STEP_LIMIT) begin
      xm     = (x % FACTOR) == '0;
      ym     = (y % FACTOR) == '0;
      diff   = (x > y) ? x - y : y - x;
      lesser = (x < y) ? x : y;
      steps++;
      if (xm && ym) begin
        x     = x / FACTOR;
        y     = y / FACTOR;
        scale = scale * FACTOR;
      end else if (xm) begin
        quo = x / FACTOR;
        y   = x[0] ? (y << 1) : diff;
        x   = quo;
      end else if (ym) begin
        quo = y / FACTOR;
        x   = y[0] ? (x << 1) : diff;
        y   = quo;
      end else begin
        x = diff;
        y = lesser;
      end
    end
    if (x != y) x = lesser_of(x, y);
    prod = scale * x;
    return prod[OW-1:0];
  endfunction

  // Result side: random stalls and the in-order check.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (gcd_expected.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %0d", $time,
                   m_axis_tdata_o[OW-1:0]);
          error_count++;
        end else begin
          if (m_axis_tdata_o[OW-1:0] !== gcd_expected[0]) begin
            $display("%0t: gcd_value mismatch: expected %0d, actual %0d", $time,
                     gcd_expected[0], m_axis_tdata_o[OW-1:0]);
            error_count++;
          end
          void'(gcd_expected.pop_front());
        end
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left      <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left      <= $urandom_range(0, 15);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("gcd_eleven_reduction_tb: errors");
      $finish;
    end
  end

  task automatic send_pair(input logic [OW-1:0] a, input logic [OW-1:0] b);
    int steps;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    gcd_expected.push_back(compute_gcd11(a, b, steps));
    // slowest case: every step, both stalls, a margin; then taken four times over
    cycle_budget += 4 * (3 + 8 * (steps + 1) + 2 * 16 + 16);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic pick_pair(output logic [OW-1:0] a, output logic [OW-1:0] b);
    logic [OW-1:0] g;
    case ($urandom_range(0, 9)) inside
      [0:1]: begin
        a = $urandom();
        b = $urandom();
      end
      [2:4]: begin
        a = $urandom_range(0, 2000);
        b = $urandom_range(0, 2000);
      end
      [5:6]: begin
        // shared factor made of powers of 11 and a small extra
        g = 1;
        repeat ($urandom_range(0, 4)) g = g * 11;
        g = g * $urandom_range(1, 30);
        a = g * $urandom_range(1, 5000);
        b = g * $urandom_range(1, 5000);
      end
      [7:8]: begin
        // one side a multiple of 11, the other drawn at random
        a = 11 * $urandom_range(1, 100000);
        b = $urandom_range(1, 100000);
        if ($urandom_range(0, 1)) begin
          g = a;
          a = b;
          b = g;
        end
      end
      default: begin
        a = $urandom();
        b = $urandom_range(0, 1) ? a : a >> $urandom_range(0, 31);
      end
    endcase
  endtask

  task automatic test_zero_operands();
    send_pair('0, '0);
    send_pair('0, 32'd12345);
    send_pair(32'd987654, '0);
    send_pair(MAX_OPERAND, '0);
    send_pair('0, MAX_OPERAND);
  endtask

  task automatic test_equal_operands();
    send_pair(32'd1, 32'd1);
    send_pair(32'd121, 32'd121);
    send_pair(MAX_OPERAND, MAX_OPERAND);
  endtask

  task automatic test_extremes();
    send_pair(MAX_OPERAND, 32'd1);
    send_pair(32'd1, MAX_OPERAND);
    send_pair(MAX_OPERAND, MAX_OPERAND - 1);
    send_pair(32'h8000_0000, 32'h5555_5555);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_factor_eleven();
    send_pair(32'd847, 32'd143);       // common factor, both sides
    send_pair(32'd1331 * 32'd97, 32'd121 * 32'd97);
    send_pair(32'd33, 32'd5);          // odd multiple: other side doubles
    send_pair(32'd7, 32'd99);
    send_pair(32'd22, 32'd7);          // even multiple: other side takes the difference
    send_pair(32'd9, 32'd44);
    send_pair(32'd10, 32'd4);          // no multiple: subtractive step
    send_pair(32'd214358881, 32'd19487171);  // 11^8 and 11^7
  endtask

  task automatic test_random_pairs(input int count);
    logic [OW-1:0] a, b;
    repeat (count) begin
      pick_pair(a, b);
      send_pair(a, b);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (gcd_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    error_count     = 0;
    idling_on       = 1'b1;
    cycle_count     = 0;
    cycle_budget    = 20000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_operands();
    test_equal_operands();
    test_extremes();
    test_factor_eleven();
    test_random_pairs(1700);
    idling_on = 1'b0;
    test_random_pairs(300);
    wait_drain();

    if (error_count == 0) begin
      $display("gcd_eleven_reduction_tb: clean");
    end else begin
      $display("gcd_eleven_reduction_tb: errors");
    end
    $finish;
  end

endmodule
